// ----- hw/rtl/mtma_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and control types for the trimmed moving average block
package mtma_pkg;

	localparam int RING_DEPTH = 64;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int BYTE_W     = 8;
	localparam int SAMPLE_W   = 12;
	localparam int WIN_W      = 7;
	localparam int SUM_W      = SAMPLE_W + IDX_W;
	localparam int DCNT_W     = $clog2(SUM_W);

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(30);
	localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(2);

	typedef struct packed {
		logic load;
		logic rd;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic rd_last;
		logic div_last;
	} stat_t;

endpackage

// ----- hw/rtl/max_trimmed_moving_average_top.sv -----
`timescale 1ns / 1ps
// top level of the max-trimmed moving average filter
//
// input channel: in_valid / in_stall with first_byte and second_byte; a word
// is taken at a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with raw_sample and filtered_value
// config: cfg_wr_en with cfg_wr_data writes the window length (reset 30),
// clamped to 2..64; write it only while the block is idle
// each input word gives one output word; no new word is taken until its
// result enters the output register; the pace is set by the ring scan
// over the n entries of the effective window (one entry per cycle over
// one read port) and the 18-step serial divider
// the output register frees the input side: a new word is taken while the
// last result waits under out_stall; its result is held back until then
// reset clears the ring valid bits (entries read as zero), the write
// position and the output valid flag
module max_trimmed_moving_average_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mtma_pkg::WIN_W-1:0]     cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mtma_pkg::BYTE_W-1:0]    first_byte,
	input  logic [mtma_pkg::BYTE_W-1:0]    second_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mtma_pkg::SAMPLE_W-1:0]  raw_sample,
	output logic [mtma_pkg::SAMPLE_W-1:0]  filtered_value
);
	import mtma_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mtma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mtma_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.first_byte     (first_byte),
		.second_byte    (second_byte),
		.cmd            (cmd),
		.stat           (stat),
		.raw_sample     (raw_sample),
		.filtered_value (filtered_value)
	);

	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (in_valid && !in_stall))
		else $error("ring load without an accepted word");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && cmd.rd))
		else $error("scan did not start after accept");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("output word overwritten while stalled");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd, cmd.div_start, cmd.div_step, cmd.out_load}))
		else $error("overlapping datapath commands");

endmodule

// ----- hw/rtl/mtma_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer for ring scan, serial divide and output handoff
module mtma_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  mtma_pkg::stat_t stat,
	output mtma_pkg::cmd_t  cmd
);
	import mtma_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		DRAIN,
		PREP,
		DIV,
		DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE:    cmd.load      = in_valid;
			SCAN:    cmd.rd        = 1'b1;
			DRAIN:   cmd           = '0;
			PREP:    cmd.div_start = 1'b1;
			DIV:     cmd.div_step  = 1'b1;
			DONE:    cmd.out_load  = out_free;
			default: cmd           = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (stat.rd_last) begin
						state_q <= DRAIN;
					end
				end
				DRAIN:   state_q <= PREP;
				PREP:    state_q <= DIV;
				DIV: begin
					if (stat.div_last) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/mtma_dp.sv -----
`timescale 1ns / 1ps
// sample ring, window accumulator, serial divider and output register
module mtma_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mtma_pkg::WIN_W-1:0]     cfg_wr_data,
	input  logic [mtma_pkg::BYTE_W-1:0]    first_byte,
	input  logic [mtma_pkg::BYTE_W-1:0]    second_byte,
	input  mtma_pkg::cmd_t                 cmd,
	output mtma_pkg::stat_t                stat,
	output logic [mtma_pkg::SAMPLE_W-1:0]  raw_sample,
	output logic [mtma_pkg::SAMPLE_W-1:0]  filtered_value
);
	import mtma_pkg::*;

	logic [WIN_W-1:0]    win_q;
	logic [IDX_W-1:0]    nm1;
	logic [IDX_W-1:0]    wp_q;
	logic [RING_DEPTH-1:0] valid_q;
	logic [SAMPLE_W-1:0] mem [RING_DEPTH];
	logic [SAMPLE_W-1:0] sample;
	logic [SAMPLE_W-1:0] sample_q;
	logic [IDX_W-1:0]    rd_addr_q;
	logic                rd_s1;
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic                rd_valid_s1;
	logic [SAMPLE_W-1:0] word;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SUM_W-1:0]    quot_q;
	logic [IDX_W-1:0]    rem_q;
	logic [IDX_W:0]      rem_sh;
	logic                q_bit;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic [SAMPLE_W-1:0] raw_q;
	logic [SAMPLE_W-1:0] filt_q;

	// effective window minus one, clamped to the ring
	always_comb begin
		if (win_q < WIN_MIN) begin
			nm1 = IDX_W'(1);
		end else if (32'(win_q) > RING_DEPTH) begin
			nm1 = IDX_W'(RING_DEPTH - 1);
		end else begin
			nm1 = IDX_W'(win_q - WIN_W'(1));
		end
	end

	assign sample = {first_byte[5:0], second_byte[7:2]};
	assign word   = rd_valid_s1 ? rd_data_s1 : '0;
	assign rem_sh = {rem_q, quot_q[SUM_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, nm1});

	assign stat.rd_last  = (rd_addr_q == nm1);
	assign stat.div_last = (div_cnt_q == DCNT_W'(SUM_W - 1));

	assign raw_sample     = raw_q;
	assign filtered_value = filt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= WIN_RESET;
			wp_q    <= '0;
			valid_q <= '0;
			rd_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				win_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				valid_q[wp_q] <= 1'b1;
				wp_q          <= (wp_q < nm1) ? wp_q + IDX_W'(1) : '0;
			end
			rd_s1 <= cmd.rd;
		end
	end

	// ring storage
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[wp_q] <= sample;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1  <= mem[rd_addr_q];
		rd_valid_s1 <= valid_q[rd_addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q  <= sample;
			rd_addr_q <= '0;
			sum_q     <= '0;
			max_q     <= '0;
		end else begin
			if (cmd.rd && !stat.rd_last) begin
				rd_addr_q <= rd_addr_q + IDX_W'(1);
			end
			if (rd_s1) begin
				sum_q <= sum_q + SUM_W'(word);
				if (word > max_q) begin
					max_q <= word;
				end
			end
		end
	end

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quot_q    <= sum_q - SUM_W'(max_q);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			quot_q    <= {quot_q[SUM_W-2:0], q_bit};
			rem_q     <= q_bit ? IDX_W'(rem_sh - {1'b0, nm1}) : rem_sh[IDX_W-1:0];
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			raw_q  <= sample_q;
			filt_q <= quot_q[SAMPLE_W-1:0];
		end
	end

endmodule
